### hdl/solid_edge_run_extractor_macros.svh
// Assertion macros used by the checker of the solid edge run extractor.
// Depends on nothing; include by bare file name.
`ifndef SOLID_EDGE_RUN_EXTRACTOR_MACROS_SVH
`define SOLID_EDGE_RUN_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SERX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serx assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SERX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serx assertion failed");

`endif

### hdl/serx_pkg.sv
// Package of the solid edge run extractor: widths, codes, segment type.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package serx_pkg;

   // Field widths of the channels
   localparam int LineW      = 8;
   localparam int TileCoordW = 9;
   localparam int CoordW     = 17;
   localparam int TileSizeW  = 9;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 9;

   // Limits of the scan and of the tile size
   localparam int MaxLineCells = 256;
   localparam int MaxTileSize  = 256;

   // Reset values of the registers
   localparam logic [TileSizeW-1:0] TileSizeReset = 9'd16;

   typedef enum logic [CsrIndexW-1:0] {
      REG_SCAN_AXIS   = 2'd0,
      REG_TILE_WIDTH  = 2'd1,
      REG_TILE_HEIGHT = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      EDGE_LEFT   = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_TOP    = 2'd2,
      EDGE_BOTTOM = 2'd3
   } edge_kind_type;

   // One segment in tile units, before scaling
   typedef struct packed {
      edge_kind_type         kind;
      logic [TileCoordW-1:0] x0;
      logic [TileCoordW-1:0] y0;
      logic [TileCoordW-1:0] x1;
      logic [TileCoordW-1:0] y1;
      logic                  last;
   } seg_type;

endpackage

### hdl/serx_if.sv
// Channel interfaces of the solid edge run extractor: cell input, segment output, registers.
// Depends on serx_pkg.
`timescale 1ns / 1ps

interface serx_req_if;
   logic                      valid;
   logic                      ready;
   logic [serx_pkg::LineW-1:0] line_index;
   logic [serx_pkg::LineW-1:0] cell_index;
   logic                      solid_first;
   logic                      solid_second;
   logic                      line_end;

   modport source (output valid, line_index, cell_index, solid_first, solid_second,
                   line_end, input ready);
   modport sink (input valid, line_index, cell_index, solid_first, solid_second,
                 line_end, output ready);
endinterface

interface serx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [serx_pkg::CoordW-1:0] start_x;
   logic [serx_pkg::CoordW-1:0] start_y;
   logic [serx_pkg::CoordW-1:0] end_x;
   logic [serx_pkg::CoordW-1:0] end_y;
   logic [1:0]                  edge_kind;
   logic                        last_of_item;

   modport source (output valid, start_x, start_y, end_x, end_y, edge_kind, last_of_item,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, edge_kind, last_of_item,
                 output ready);
endinterface

interface serx_csr_if;
   logic                           valid;
   logic                           ready;
   logic [serx_pkg::CsrIndexW-1:0] index;
   logic [serx_pkg::CsrDataW-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/solid_edge_run_extractor.sv
// Solid edge run extractor: run tracking per solidity flag, segment scaling to pixels.
// Depends on serx_pkg and the channel interfaces in serx_if.sv.
//
// Usage:
//   req_ch carries one tile cell per item along the current grid line. Each
//   flag opens a run when set and closes it on the first clear cell; a cell
//   with line_end set flushes any open run, ending one cell past it.
//   rsp_ch carries wall segments in pixels; an item causes zero, one or two
//   segments (first flag before second), last_of_item marks the final one.
//   csr_ch writes scan_axis, tile_width, tile_height by index; it is always
//   ready; the user must write it only while the block is idle, which the block does not enforce.
// Path: a segment of an accepted item goes through the pending stage, then
//   the output register, before it shows on rsp_ch.
// Throughput: one item per cycle while rsp_ch is not stalled and items cause at
//   most one segment; an item with two segments holds the pending stage until
//   its second segment leaves, since the output register moves one segment per cycle.
// Reset: run state clears, registers return to column scan and 16x16 tiles,
//   no segment is pending.
// Stall: while rsp_ch is stalled the output register holds its segment, and a
//   new item is taken only if the pending stage is empty.
`timescale 1ns / 1ps

module solid_edge_run_extractor (
   input logic         clock,
   input logic         reset,
   serx_req_if.sink    req_ch,
   serx_rsp_if.source  rsp_ch,
   serx_csr_if.sink    csr_ch
);

   localparam int LineW = serx_pkg::LineW;
   localparam int TcW   = serx_pkg::TileCoordW;
   localparam int TsW   = serx_pkg::TileSizeW;
   localparam int CW    = serx_pkg::CoordW;

   // Configuration registers
   logic           scan_axis_ff;
   logic [TsW-1:0] tile_width_ff;
   logic [TsW-1:0] tile_height_ff;

   // Run tracker state
   logic             first_open_ff,  first_open_in;
   logic             second_open_ff, second_open_in;
   logic [LineW-1:0] first_start_ff,  first_start_in;
   logic [LineW-1:0] second_start_ff, second_start_in;

   // Pending segments of the last accepted item
   logic                  pend_v0_ff, pend_v0_in;
   logic                  pend_v1_ff, pend_v1_in;
   serx_pkg::seg_type     pend_s0_ff, pend_s0_in;
   serx_pkg::seg_type     pend_s1_ff, pend_s1_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;
   serx_pkg::edge_kind_type rsp_kind_ff;
   logic                    rsp_last_ff;

   logic req_take;
   logic out_move;

   // Build one segment in tile units from a run [s, e) on line ln
   function automatic serx_pkg::seg_type make_seg(input logic axis, input logic second,
                                                  input logic [LineW-1:0] ln,
                                                  input logic [LineW-1:0] s,
                                                  input logic [TcW-1:0] e);
      serx_pkg::seg_type seg;
      logic [TcW-1:0]    l0;
      logic [TcW-1:0]    l1;
      logic [TcW-1:0]    sw;
      l0 = {1'b0, ln};
      l1 = {1'b0, ln} + TcW'(1);
      sw = {1'b0, s};
      seg.last = 1'b1;
      if (!axis) begin
         if (!second) begin
            seg.kind = serx_pkg::EDGE_LEFT;
            seg.x0 = l0; seg.y0 = sw; seg.x1 = l0; seg.y1 = e;
         end else begin
            seg.kind = serx_pkg::EDGE_RIGHT;
            seg.x0 = l1; seg.y0 = e; seg.x1 = l1; seg.y1 = sw;
         end
      end else begin
         if (!second) begin
            seg.kind = serx_pkg::EDGE_TOP;
            seg.x0 = e; seg.y0 = l0; seg.x1 = sw; seg.y1 = l0;
         end else begin
            seg.kind = serx_pkg::EDGE_BOTTOM;
            seg.x0 = sw; seg.y0 = l1; seg.x1 = e; seg.y1 = l1;
         end
      end
      return seg;
   endfunction

   // Force a tile size into 1 .. MaxTileSize
   function automatic logic [TsW-1:0] clamp_tile(input logic [TsW-1:0] t);
      logic [TsW-1:0] r;
      if (t == '0) begin
         r = TsW'(1);
      end else if (32'(t) > serx_pkg::MaxTileSize) begin
         r = TsW'(serx_pkg::MaxTileSize);
      end else begin
         r = t;
      end
      return r;
   endfunction

   // Scale a tile coordinate to pixels, low bits only
   function automatic logic [CW-1:0] scale(input logic [TcW-1:0] c, input logic [TsW-1:0] t);
      logic [TcW+TsW-1:0] p;
      p = (TcW+TsW)'(c) * (TcW+TsW)'(t);
      return p[CW-1:0];
   endfunction

   // Handshakes
   assign out_move     = pend_v0_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pend_v0_ff || (!pend_v1_ff && out_move);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Run tracking and segment selection for the incoming item
   logic [TcW-1:0]    flush_end;
   logic [TcW-1:0]    cell_end;
   logic              f1_end, f1_flush, f2_end, f2_flush, f1_emit, f2_emit;
   serx_pkg::seg_type seg_a, seg_b;

   always_comb begin
      cell_end = {1'b0, req_ch.cell_index};
      if (32'(req_ch.cell_index) + 1 > serx_pkg::MaxLineCells) begin
         flush_end = TcW'(serx_pkg::MaxLineCells);
      end else begin
         flush_end = cell_end + TcW'(1);
      end

      f1_end   = first_open_ff && !req_ch.solid_first;
      f1_flush = req_ch.line_end && (first_open_ff || req_ch.solid_first) && !f1_end;
      f2_end   = second_open_ff && !req_ch.solid_second;
      f2_flush = req_ch.line_end && (second_open_ff || req_ch.solid_second) && !f2_end;
      f1_emit  = f1_end || f1_flush;
      f2_emit  = f2_end || f2_flush;

      seg_a = make_seg(scan_axis_ff, 1'b0, req_ch.line_index,
                       first_open_ff ? first_start_ff : req_ch.cell_index,
                       f1_end ? cell_end : flush_end);
      seg_b = make_seg(scan_axis_ff, 1'b1, req_ch.line_index,
                       second_open_ff ? second_start_ff : req_ch.cell_index,
                       f2_end ? cell_end : flush_end);

      // Advance run state on an accepted item
      first_open_in   = first_open_ff;
      second_open_in  = second_open_ff;
      first_start_in  = first_start_ff;
      second_start_in = second_start_ff;
      if (req_take) begin
         first_open_in  = req_ch.solid_first && !req_ch.line_end;
         second_open_in = req_ch.solid_second && !req_ch.line_end;
         if (!first_open_ff && req_ch.solid_first) begin
            first_start_in = req_ch.cell_index;
         end
         if (!second_open_ff && req_ch.solid_second) begin
            second_start_in = req_ch.cell_index;
         end
      end
   end

   // Load, shift or hold the pending stage
   always_comb begin
      pend_v0_in = pend_v0_ff;
      pend_v1_in = pend_v1_ff;
      pend_s0_in = pend_s0_ff;
      pend_s1_in = pend_s1_ff;
      if (req_take) begin
         pend_v0_in      = f1_emit || f2_emit;
         pend_v1_in      = f1_emit && f2_emit;
         pend_s0_in      = f1_emit ? seg_a : seg_b;
         pend_s0_in.last = !(f1_emit && f2_emit);
         pend_s1_in      = seg_b;
      end else if (out_move) begin
         pend_v0_in = pend_v1_ff;
         pend_v1_in = 1'b0;
         pend_s0_in = pend_s1_ff;
      end
   end

   assign rsp_valid_in = out_move || (rsp_valid_ff && !rsp_ch.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_axis_ff   <= 1'b0;
         tile_width_ff  <= serx_pkg::TileSizeReset;
         tile_height_ff <= serx_pkg::TileSizeReset;
         first_open_ff  <= 1'b0;
         second_open_ff <= 1'b0;
         pend_v0_ff     <= 1'b0;
         pend_v1_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               serx_pkg::REG_SCAN_AXIS:   scan_axis_ff   <= csr_ch.data[0];
               serx_pkg::REG_TILE_WIDTH:  tile_width_ff  <= csr_ch.data;
               serx_pkg::REG_TILE_HEIGHT: tile_height_ff <= csr_ch.data;
               default: ;
            endcase
         end
         first_open_ff  <= first_open_in;
         second_open_ff <= second_open_in;
         pend_v0_ff     <= pend_v0_in;
         pend_v1_ff     <= pend_v1_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload: run starts, pending segments, scaled output segment
   always_ff @(posedge clock) begin
      first_start_ff  <= first_start_in;
      second_start_ff <= second_start_in;
      pend_s0_ff      <= pend_s0_in;
      pend_s1_ff      <= pend_s1_in;
      if (out_move) begin
         rsp_sx_ff   <= scale(pend_s0_ff.x0, clamp_tile(tile_width_ff));
         rsp_sy_ff   <= scale(pend_s0_ff.y0, clamp_tile(tile_height_ff));
         rsp_ex_ff   <= scale(pend_s0_ff.x1, clamp_tile(tile_width_ff));
         rsp_ey_ff   <= scale(pend_s0_ff.y1, clamp_tile(tile_height_ff));
         rsp_kind_ff <= pend_s0_ff.kind;
         rsp_last_ff <= pend_s0_ff.last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.start_x      = rsp_sx_ff;
   assign rsp_ch.start_y      = rsp_sy_ff;
   assign rsp_ch.end_x        = rsp_ex_ff;
   assign rsp_ch.end_y        = rsp_ey_ff;
   assign rsp_ch.edge_kind    = rsp_kind_ff;
   assign rsp_ch.last_of_item = rsp_last_ff;

endmodule

### hdl/serx_checker.sv
// Port-level checker of the solid edge run extractor, bound to the top level.
// Depends on solid_edge_run_extractor_macros.svh and serx_pkg.
`timescale 1ns / 1ps
`include "solid_edge_run_extractor_macros.svh"

module serx_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_solid_first,
   input logic                        req_solid_second,
   input logic                        req_line_end,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [serx_pkg::CoordW-1:0] rsp_start_x,
   input logic [serx_pkg::CoordW-1:0] rsp_end_y,
   input logic [1:0]                  rsp_edge_kind,
   input logic                        rsp_last_of_item
);

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Hold a stalled segment
   `SERX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SERX_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_start_x) && $stable(rsp_end_y) && $stable(rsp_edge_kind))

   // A line end with a set flag always flushes a segment
   `SERX_ASSERT_NEXT(a_flush_emits, clock, reset,
      req_take && req_line_end && (req_solid_first || req_solid_second), ##1 rsp_valid)

   // A segment that is not the last of its item is followed at once by another
   `SERX_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_take && !rsp_last_of_item, rsp_valid)

endmodule

bind solid_edge_run_extractor serx_checker u_serx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_solid_first  (req_ch.solid_first),
   .req_solid_second (req_ch.solid_second),
   .req_line_end     (req_ch.line_end),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_start_x      (rsp_ch.start_x),
   .rsp_end_y        (rsp_ch.end_y),
   .rsp_edge_kind    (rsp_ch.edge_kind),
   .rsp_last_of_item (rsp_ch.last_of_item)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Bench for the solid edge run extractor: directed and random cell streams with
// both scan axes and many tile sizes, each wall segment checked against a local run tracker.
// Depends on serx_pkg, the channel interfaces in serx_if.sv and the top level.

module tb;

   localparam int ClockPeriod  = 10;
   localparam int ResetCycles  = 9;
   localparam int CycleLimit   = 400000;
   localparam int IdlePercent  = 37;
   localparam int HoldCycles   = 150;
   localparam int SettleCycles = 6;
   localparam int MaxReports   = 60;

   localparam int LineW       = serx_pkg::LineW;
   localparam int CoordW      = serx_pkg::CoordW;
   localparam int TileSizeW   = serx_pkg::TileSizeW;
   localparam int CsrDataW    = serx_pkg::CsrDataW;
   localparam int MaxTileSize = serx_pkg::MaxTileSize;

   // One wall segment in pixels, as it leaves the block
   typedef struct {
      logic [CoordW-1:0]       start_x;
      logic [CoordW-1:0]       start_y;
      logic [CoordW-1:0]       end_x;
      logic [CoordW-1:0]       end_y;
      serx_pkg::edge_kind_type kind;
      logic                    last;
   } wall_seg_type;

   logic        clock;
   logic        reset;
   int unsigned cycle_count = 0;
   int          mismatch_count = 0;
   int          cells_sent = 0;
   int          walls_checked = 0;
   int          tile_settings = 0;
   bit          req_gaps = 1'b1;
   bit          rsp_stalls = 1'b1;
   int          hold_requests = 0;
   int          holds_done = 0;

   // Local copy of the registers and of the two run trackers
   logic                 axis_row;
   logic [TileSizeW-1:0] tile_w;
   logic [TileSizeW-1:0] tile_h;
   logic                 first_open;
   logic                 second_open;
   logic [LineW-1:0]     first_start;
   logic [LineW-1:0]     second_start;
   wall_seg_type         expected_walls[$];

   serx_req_if req_ch();
   serx_rsp_if rsp_ch();
   serx_csr_if csr_ch();

   solid_edge_run_extractor uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // End the run if it hangs
   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("timeout after %0d cycles, %0d segments still expected",
               cycle_count, expected_walls.size());
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   // Scale a tile coordinate to pixels; out-of-range tile sizes saturate
   function automatic logic [CoordW-1:0] to_pixels(logic [8:0] tiles,
                                                   logic [TileSizeW-1:0] size);
      logic [TileSizeW-1:0] eff;
      logic [17:0]          prod;
      eff = size;
      if (size == 0) eff = TileSizeW'(1);
      else if (size > MaxTileSize) eff = TileSizeW'(MaxTileSize);
      prod = 18'(tiles) * 18'(eff);
      return prod[CoordW-1:0];
   endfunction

   function automatic wall_seg_type make_wall(serx_pkg::edge_kind_type kind, logic [8:0] x0,
                                              logic [8:0] y0, logic [8:0] x1, logic [8:0] y1);
      wall_seg_type w;
      w.kind    = kind;
      w.start_x = to_pixels(x0, tile_w);
      w.start_y = to_pixels(y0, tile_h);
      w.end_x   = to_pixels(x1, tile_w);
      w.end_y   = to_pixels(y1, tile_h);
      w.last    = 1'b0;
      return w;
   endfunction

   // Turn a finished run (start s, exclusive end e) into a wall on the current axis
   function automatic wall_seg_type run_to_wall(bit second, logic [LineW-1:0] line,
                                                logic [8:0] s, logic [8:0] e);
      logic [8:0] ln;
      logic [8:0] lp;
      ln = {1'b0, line};
      lp = ln + 9'd1;
      if (!axis_row) begin
         if (!second) return make_wall(serx_pkg::EDGE_LEFT, ln, s, ln, e);
         return make_wall(serx_pkg::EDGE_RIGHT, lp, e, lp, s);
      end
      if (!second) return make_wall(serx_pkg::EDGE_TOP, e, ln, s, ln);
      return make_wall(serx_pkg::EDGE_BOTTOM, s, lp, e, lp);
   endfunction

   // Advance both run trackers by one cell and queue the walls it closes
   task automatic track_cell(logic [LineW-1:0] line, logic [LineW-1:0] cell_ix,
                             logic f1, logic f2, logic line_last);
      wall_seg_type walls[$];
      logic [8:0]   flush_end;
      flush_end = {1'b0, cell_ix} + 9'd1;
      if (first_open && !f1) begin
         walls.insert(walls.size(),
                      run_to_wall(1'b0, line, {1'b0, first_start}, {1'b0, cell_ix}));
         first_open = 1'b0;
      end else if (!first_open && f1) begin
         first_start = cell_ix;
         first_open  = 1'b1;
      end
      if (line_last && first_open) begin
         walls.insert(walls.size(), run_to_wall(1'b0, line, {1'b0, first_start}, flush_end));
         first_open = 1'b0;
      end
      if (second_open && !f2) begin
         walls.insert(walls.size(),
                      run_to_wall(1'b1, line, {1'b0, second_start}, {1'b0, cell_ix}));
         second_open = 1'b0;
      end else if (!second_open && f2) begin
         second_start = cell_ix;
         second_open  = 1'b1;
      end
      if (line_last && second_open) begin
         walls.insert(walls.size(), run_to_wall(1'b1, line, {1'b0, second_start}, flush_end));
         second_open = 1'b0;
      end
      if (walls.size() > 0) walls[walls.size() - 1].last = 1'b1;
      foreach (walls[i]) expected_walls.insert(expected_walls.size(), walls[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [CoordW-1:0] got,
                                  logic [CoordW-1:0] want);
      if (mismatch_count < MaxReports)
         $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_wall();
      wall_seg_type want;
      if (expected_walls.size() == 0) begin
         report_mismatch("segment with none expected", rsp_ch.start_x, '0);
         return;
      end
      want = expected_walls.pop_front();
      walls_checked++;
      if (rsp_ch.start_x !== want.start_x) report_mismatch("start_x", rsp_ch.start_x, want.start_x);
      if (rsp_ch.start_y !== want.start_y) report_mismatch("start_y", rsp_ch.start_y, want.start_y);
      if (rsp_ch.end_x !== want.end_x) report_mismatch("end_x", rsp_ch.end_x, want.end_x);
      if (rsp_ch.end_y !== want.end_y) report_mismatch("end_y", rsp_ch.end_y, want.end_y);
      if (rsp_ch.edge_kind !== want.kind)
         report_mismatch("edge_kind", CoordW'(rsp_ch.edge_kind), CoordW'(want.kind));
      if (rsp_ch.last_of_item !== want.last)
         report_mismatch("last_of_item", CoordW'(rsp_ch.last_of_item), CoordW'(want.last));
   endtask

   // Check results first, then follow register writes and accepted items
   always @(posedge clock) begin
      if (reset) begin
         axis_row     = 1'b0;
         tile_w       = serx_pkg::TileSizeReset;
         tile_h       = serx_pkg::TileSizeReset;
         first_open   = 1'b0;
         second_open  = 1'b0;
         first_start  = '0;
         second_start = '0;
         expected_walls.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_wall();
         if (csr_ch.valid && csr_ch.ready) begin
            case (serx_pkg::reg_index_type'(csr_ch.index))
               serx_pkg::REG_SCAN_AXIS:   axis_row = csr_ch.data[0];
               serx_pkg::REG_TILE_WIDTH:  tile_w = csr_ch.data;
               serx_pkg::REG_TILE_HEIGHT: tile_h = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            track_cell(req_ch.line_index, req_ch.cell_index, req_ch.solid_first,
                       req_ch.solid_second, req_ch.line_end);
      end
   end

   // ---------------------------------------------------------------- result side

   // Stall at random, or hold off for a long stretch when asked
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            holds_done++;
         end
         rsp_ch.ready <= !(rsp_stalls && $urandom_range(99) < IdlePercent);
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_cell(logic [LineW-1:0] line, logic [LineW-1:0] cell_ix,
                            logic f1, logic f2, logic line_last);
      if (req_gaps && $urandom_range(99) < IdlePercent) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IdlePercent);
      end
      req_ch.valid        <= 1'b1;
      req_ch.line_index   <= line;
      req_ch.cell_index   <= cell_ix;
      req_ch.solid_first  <= f1;
      req_ch.solid_second <= f2;
      req_ch.line_end     <= line_last;
      do @(posedge clock); while (!req_ch.ready);
      cells_sent++;
   endtask

   // Drop valid and wait until every expected segment has come out
   task automatic wait_walls_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_walls.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(serx_pkg::reg_index_type idx, logic [CsrDataW-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_scan(logic axis, logic [CsrDataW-1:0] width, logic [CsrDataW-1:0] height);
      wait_walls_drained();
      write_reg(serx_pkg::REG_SCAN_AXIS, {8'd0, axis});
      write_reg(serx_pkg::REG_TILE_WIDTH, width);
      write_reg(serx_pkg::REG_TILE_HEIGHT, height);
      tile_settings++;
   endtask

   // Mostly well-formed lines with random runs; some lines lack the end
   // marker and some cells are pure noise
   task automatic stream_random_lines(int count);
      int         sent;
      int         len;
      int         first_cell;
      int         style;
      logic [7:0] line;
      logic       f1;
      logic       f2;
      sent = 0;
      while (sent < count) begin
         style      = $urandom_range(99);
         line       = 8'($urandom_range(255));
         len        = ($urandom_range(99) < 3) ? $urandom_range(200, 256) : $urandom_range(1, 16);
         first_cell = $urandom_range(256 - len);
         f1         = 1'($urandom_range(1));
         f2         = 1'($urandom_range(1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 30) f1 = ~f1;
            if ($urandom_range(99) < 30) f2 = ~f2;
            if (style < 82)
               send_cell(line, 8'(first_cell + i), f1, f2, i == len - 1);
            else if (style < 91)
               send_cell(line, 8'(first_cell + i), f1, f2, 1'b0);
            else
               send_cell(8'($urandom_range(255)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
         end
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Column scan at reset settings: closing, flushing, both walls on one cell
   task automatic test_column_directed();
      send_cell(8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
      send_cell(8'd0, 8'd1, 1'b1, 1'b0, 1'b0);
      send_cell(8'd0, 8'd2, 1'b0, 1'b1, 1'b0);
      send_cell(8'd0, 8'd3, 1'b0, 1'b0, 1'b1);
      send_cell(8'd255, 8'd0, 1'b1, 1'b1, 1'b0);
      send_cell(8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
      // single-cell run flushed on its own line end
      send_cell(8'd7, 8'd10, 1'b1, 1'b0, 1'b1);
      // line changes without an end marker: run carries over
      send_cell(8'd7, 8'd0, 1'b0, 1'b1, 1'b0);
      send_cell(8'd8, 8'd5, 1'b0, 1'b0, 1'b0);
      // cells out of order: end before start
      send_cell(8'd3, 8'd200, 1'b1, 1'b1, 1'b0);
      send_cell(8'd3, 8'd100, 1'b0, 1'b0, 1'b0);
      send_cell(8'd3, 8'd50, 1'b0, 1'b0, 1'b1);
      send_cell(8'd128, 8'd254, 1'b1, 1'b0, 1'b0);
      send_cell(8'd128, 8'd255, 1'b0, 1'b1, 1'b1);
   endtask

   // Row scan, saturating tile sizes, axis switched in the middle of a line
   task automatic test_row_and_tile_limits();
      set_scan(1'b1, 9'd0, 9'd511);
      send_cell(8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
      send_cell(8'd0, 8'd3, 1'b0, 1'b0, 1'b0);
      send_cell(8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
      set_scan(1'b1, 9'd257, 9'd1);
      send_cell(8'd200, 8'd10, 1'b1, 1'b0, 1'b0);
      send_cell(8'd200, 8'd20, 1'b1, 1'b1, 1'b1);
      send_cell(8'd9, 8'd4, 1'b1, 1'b1, 1'b0);
      set_scan(1'b0, 9'd256, 9'd256);
      send_cell(8'd9, 8'd6, 1'b0, 1'b1, 1'b0);
      set_scan(1'b1, 9'd256, 9'd256);
      send_cell(8'd255, 8'd0, 1'b1, 1'b1, 1'b0);
      send_cell(8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
   endtask

   // A long stretch with no idling on either side
   task automatic test_unbroken_stream();
      set_scan(1'b0, 9'd16, 9'd8);
      req_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      stream_random_lines(200);
      wait_walls_drained();
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
   endtask

   // Receiver holds off while cells keep coming, so the block backs up
   task automatic test_output_hold();
      set_scan(1'b1, 9'd12, 9'd20);
      req_gaps = 1'b0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 60; i++)
         send_cell(8'd77, 8'(i), i[0], i[0] ^ i[2], i == 59);
      req_gaps = 1'b1;
   endtask

   // Random lines under a range of axis and tile size settings
   task automatic test_random_sweep();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_scan(1'b1, 9'd1, 9'd256);
            1: set_scan(1'b0, 9'd256, 9'd1);
            2: set_scan(1'b1, 9'd0, 9'd511);
            3: set_scan(1'b0, 9'd300, 9'd0);
            default: set_scan(1'($urandom_range(1)), 9'($urandom_range(511)),
                              9'($urandom_range(511)));
         endcase
         stream_random_lines(140);
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.line_index   = '0;
      req_ch.cell_index   = '0;
      req_ch.solid_first  = 1'b0;
      req_ch.solid_second = 1'b0;
      req_ch.line_end     = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_column_directed();
      test_row_and_tile_limits();
      test_unbroken_stream();
      test_output_hold();
      test_random_sweep();
      wait_walls_drained();

      $display("Sent %0d cells over both scan axes under %0d register settings,",
               cells_sent, tile_settings);
      $display("with saturating tile sizes and a long output stall; %0d wall segments checked.",
               walls_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
